// File: hw/rtl/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package mhpq_pkg;

  // heap geometry
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = ADDR_W + 2;

  // fixed field widths
  localparam int KEY_W   = 32;
  localparam int CAP_W   = 7;
  localparam int ENTRY_W = 7;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_PEEK    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic                      valid;
    logic signed [KEY_W-1:0]   key;
    status_t                   status;
    logic        [ENTRY_W-1:0] count;
  } res_t;

endpackage

// File: hw/rtl/mhpq_if.sv
// Request and response channel interfaces of the min-heap priority queue.
// Depends on mhpq_pkg for the field types and widths.
`timescale 1ns / 1ps

interface mhpq_req_if;
  logic                                valid;
  logic                                ready;
  mhpq_pkg::opcode_t                   opcode;
  logic signed [mhpq_pkg::KEY_W-1:0]   key_in;

  modport source (output valid, output opcode, output key_in, input ready);
  modport sink   (input valid, input opcode, input key_in, output ready);
endinterface

interface mhpq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [mhpq_pkg::KEY_W-1:0]   key_out;
  mhpq_pkg::status_t                   status;
  logic        [mhpq_pkg::ENTRY_W-1:0] entry_count;

  modport source (output valid, output key_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input key_out, input status, input entry_count,
                  output ready);
endinterface

// File: hw/rtl/mhpq_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  output logic [DW-1:0] rdata_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered read data
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/mhpq_ctrl.sv
// Heap sequencer: runs insert, remove, replace and peek against the key RAM.
// Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  mhpq_pkg::opcode_t                   req_opcode,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   req_key,
  input  logic        [mhpq_pkg::CAP_W-1:0]   cap,
  input  logic                                res_free,
  output logic                                idle,
  output mhpq_pkg::res_t                      res
);

  localparam int AW = mhpq_pkg::ADDR_W;
  localparam int KW = mhpq_pkg::KEY_W;

  mhpq_pkg::state_t state, state_next;
  mhpq_pkg::opcode_t op, op_next;
  mhpq_pkg::status_t status, status_next;
  logic [AW-1:0] pos, pos_next;
  logic [mhpq_pkg::CNT_W-1:0] fill, fill_next;
  logic signed [KW-1:0] key_hold, key_hold_next;
  logic signed [KW-1:0] result, result_next;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [KW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [KW-1:0] mem_rdata_a;
  logic [KW-1:0] mem_rdata_b;

  // child and parent positions of the moving hole
  logic [mhpq_pkg::IDX_W-1:0] left_idx, right_idx, fill_idx;
  logic [AW-1:0] parent;
  logic signed [KW-1:0] left_key, right_key, pick_key;
  logic [AW-1:0] pick_addr;
  logic full;

  assign left_idx  = mhpq_pkg::IDX_W'({pos, 1'b1});
  assign right_idx = left_idx + 1'b1;
  assign fill_idx  = mhpq_pkg::IDX_W'(fill);
  assign parent    = AW'((pos - 1'b1) >> 1);
  assign left_key  = $signed(mem_rdata_a);
  assign right_key = $signed(mem_rdata_b);

  // smaller child, left wins ties, right only when it exists
  always_comb begin
    pick_key  = left_key;
    pick_addr = left_idx[AW-1:0];
    if (right_idx < fill_idx && right_key < left_key) begin
      pick_key  = right_key;
      pick_addr = right_idx[AW-1:0];
    end
  end

  // effective capacity saturates at the built depth
  always_comb begin
    logic [mhpq_pkg::CMP_W-1:0] cap_ext, cap_eff, fill_ext;
    cap_ext  = mhpq_pkg::CMP_W'(cap);
    fill_ext = mhpq_pkg::CMP_W'(fill);
    cap_eff  = (cap_ext > mhpq_pkg::CMP_W'(mhpq_pkg::DEPTH))
               ? mhpq_pkg::CMP_W'(mhpq_pkg::DEPTH) : cap_ext;
    full     = (fill_ext >= cap_eff);
  end

  mhpq_ram #(
    .AW (AW),
    .DW (KW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .rdata_a (mem_rdata_a),
    .raddr_b (mem_raddr_b),
    .rdata_b (mem_rdata_b)
  );

  // state and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    status   <= status_next;
    pos      <= pos_next;
    key_hold <= key_hold_next;
    result   <= result_next;
  end

  // sequencer: reads and writes alternate, so no entry is read while written
  always_comb begin
    state_next    = state;
    op_next       = op;
    status_next   = status;
    pos_next      = pos;
    fill_next     = fill;
    key_hold_next = key_hold;
    result_next   = result;
    mem_we        = 1'b0;
    mem_waddr     = pos;
    mem_wdata     = key_hold;
    mem_raddr_a   = '0;
    mem_raddr_b   = AW'(fill - 1'b1);
    idle          = 1'b0;
    res.valid     = 1'b0;
    res.key       = result;
    res.status    = status;
    res.count     = mhpq_pkg::ENTRY_W'(fill);

    unique case (state)
      mhpq_pkg::S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          op_next       = req_opcode;
          key_hold_next = req_key;
          result_next   = '0;
          status_next   = mhpq_pkg::ST_OK;
          if (req_opcode == mhpq_pkg::OP_INSERT) begin
            if (full) begin
              status_next = mhpq_pkg::ST_FULL;
              state_next  = mhpq_pkg::S_DONE;
            end else begin
              pos_next   = AW'(fill);
              fill_next  = fill + 1'b1;
              state_next = mhpq_pkg::S_UP_RD;
            end
          end else if (fill == '0) begin
            status_next = mhpq_pkg::ST_EMPTY;
            state_next  = mhpq_pkg::S_DONE;
          end else begin
            // root on port a, last entry on port b
            state_next = mhpq_pkg::S_ROOT;
          end
        end
      end

      mhpq_pkg::S_ROOT: begin
        result_next = left_key;
        pos_next    = '0;
        unique case (op) inside
          mhpq_pkg::OP_REMOVE: begin
            fill_next = fill - 1'b1;
            if (fill != mhpq_pkg::CNT_W'(1)) begin
              key_hold_next = right_key;
              state_next    = mhpq_pkg::S_DN_RD;
            end else begin
              state_next = mhpq_pkg::S_DONE;
            end
          end
          mhpq_pkg::OP_REPLACE: begin
            state_next = mhpq_pkg::S_DN_RD;
          end
          mhpq_pkg::OP_PEEK, mhpq_pkg::OP_INSERT: begin
            state_next = mhpq_pkg::S_DONE;
          end
        endcase
      end

      // sift up: move parents down into the hole until the key fits
      mhpq_pkg::S_UP_RD: begin
        if (pos == '0) begin
          mem_we     = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          mem_raddr_a = parent;
          state_next  = mhpq_pkg::S_UP_CMP;
        end
      end

      mhpq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (key_hold < left_key) begin
          mem_wdata  = mem_rdata_a;
          pos_next   = parent;
          state_next = mhpq_pkg::S_UP_RD;
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end

      // sift down: move the smaller child up into the hole
      mhpq_pkg::S_DN_RD: begin
        if (left_idx >= fill_idx) begin
          mem_we     = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          mem_raddr_a = left_idx[AW-1:0];
          mem_raddr_b = right_idx[AW-1:0];
          state_next  = mhpq_pkg::S_DN_CMP;
        end
      end

      mhpq_pkg::S_DN_CMP: begin
        mem_we = 1'b1;
        if (pick_key < key_hold) begin
          mem_wdata  = KW'(pick_key);
          pos_next   = pick_addr;
          state_next = mhpq_pkg::S_DN_RD;
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end

      mhpq_pkg::S_DONE: begin
        res.valid = 1'b1;
        if (res_free) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/min_heap_priority_queue.sv
// Top level of the min-heap priority queue: channels, capacity register, result register.
// Depends on mhpq_pkg, mhpq_if and mhpq_ctrl.
`timescale 1ns / 1ps

// Binary min-heap of signed 32-bit keys held in a 64-entry RAM with two read
// ports and one write port. One request is worked at a time. Errors (empty or
// full) go straight to the result and peek reads the root. Insert sifts the
// new key up from the end of the heap; remove and replace read the root, then
// sift the moving key down from it. The sift loop alternates a read state,
// which reads a parent or both children, with a compare state, which compares
// and writes back. A new request is taken while the previous result still
// waits in the output register. The store needs no clearing after reset; only
// entries below the fill count are ever used.

module min_heap_priority_queue (
  input  logic                                clk,
  input  logic                                rst,
  mhpq_req_if.sink                            req,
  mhpq_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic        [mhpq_pkg::CAP_W-1:0]   cfg_wdata
);

  logic [mhpq_pkg::CAP_W-1:0] capacity_limit;
  logic start;
  logic idle;
  logic res_free;
  mhpq_pkg::res_t res;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= mhpq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign res_free  = !rsp.valid || rsp.ready;

  mhpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req_opcode (req.opcode),
    .req_key    (req.key_in),
    .cap        (capacity_limit),
    .res_free   (res_free),
    .idle       (idle),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_free) begin
      rsp.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      rsp.key_out     <= res.key;
      rsp.status      <= res.status;
      rsp.entry_count <= res.count;
    end
  end

endmodule

// File: hw/rtl/mhpq_checker.sv
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and min_heap_priority_queue.
`timescale 1ns / 1ps

module mhpq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [mhpq_pkg::KEY_W-1:0]   rsp_key_out,
  input logic        [1:0]                   rsp_status,
  input logic        [mhpq_pkg::ENTRY_W-1:0] rsp_entry_count
);

  // a stalled response keeps its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_key_out)
      && $stable(rsp_status) && $stable(rsp_entry_count))
    else $error("response changed while stalled");

  // one request at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // error results carry a zero key
  a_err_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != mhpq_pkg::ST_OK |-> rsp_key_out == '0)
    else $error("nonzero key on error result");

  // empty status only with an empty heap
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == mhpq_pkg::ST_EMPTY |-> rsp_entry_count == '0)
    else $error("empty status with entries held");

  // count never exceeds the built depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_entry_count <= mhpq_pkg::ENTRY_W'(mhpq_pkg::DEPTH))
    else $error("entry count above depth");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_key_out     (rsp.key_out),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count)
);

// File: test/min_heap_priority_queue_checker.sv
// Scoreboard for the min-heap priority queue: watches the request, response and
// capacity ports, predicts each response and compares it field by field.
// Depends on mhpq_pkg and the channel interfaces in mhpq_if.
`timescale 1ns / 1ps

module min_heap_priority_queue_checker
  import mhpq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  mhpq_req_if              req,
  mhpq_rsp_if              rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               outstanding,
  output int               checked_count,
  output int               full_count,
  output int               empty_count
);

  typedef struct {
    logic signed [KEY_W-1:0]   key;
    status_t                   status;
    logic        [ENTRY_W-1:0] count;
  } heap_result_t;

  // shadow heap, its fill level and the capacity setting
  logic signed [KEY_W-1:0] heap_keys [DEPTH];
  int                      heap_fill;
  logic        [CAP_W-1:0] heap_cap;

  heap_result_t            queued_results [$];
  heap_result_t            predicted;
  heap_result_t            oldest;
  int                      errs;
  int                      n_checked;
  int                      n_full;
  int                      n_empty;

  initial begin
    errs          = 0;
    n_checked     = 0;
    n_full        = 0;
    n_empty       = 0;
  end

  function automatic void swap_keys(input int a, input int b);
    logic signed [KEY_W-1:0] t;
    t            = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  // move a new key up while it is strictly below its parent
  function automatic void heap_rise(input int start);
    int pos;
    int parent;
    bit done;
    pos  = start;
    done = 1'b0;
    while (!done && pos > 0) begin
      parent = (pos - 1) / 2;
      if (heap_keys[pos] < heap_keys[parent]) begin
        swap_keys(pos, parent);
        pos = parent;
      end else begin
        done = 1'b1;
      end
    end
  endfunction

  // push the root down; right child only if present, left wins on a tie
  function automatic void heap_sink();
    int pos;
    int left;
    int right;
    int pick;
    bit done;
    pos  = 0;
    done = 1'b0;
    while (!done) begin
      left  = 2 * pos + 1;
      right = left + 1;
      if (left >= heap_fill) begin
        done = 1'b1;
      end else begin
        pick = left;
        if (right < heap_fill && heap_keys[right] < heap_keys[left])
          pick = right;
        if (heap_keys[pick] < heap_keys[pos]) begin
          swap_keys(pos, pick);
          pos = pick;
        end else begin
          done = 1'b1;
        end
      end
    end
  endfunction

  // apply one request to the shadow heap and return its response
  function automatic heap_result_t heap_predict(input opcode_t op,
                                                input logic signed [KEY_W-1:0] key);
    heap_result_t r;
    int           cap_eff;
    cap_eff  = (heap_cap > DEPTH) ? DEPTH : int'(heap_cap);
    r.key    = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= cap_eff) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_fill] = key;
        heap_fill++;
        heap_rise(heap_fill - 1);
      end
    end else if (heap_fill == 0) begin
      r.status = ST_EMPTY;
    end else if (op == OP_REMOVE) begin
      r.key = heap_keys[0];
      heap_fill--;
      if (heap_fill > 0) begin
        heap_keys[0] = heap_keys[heap_fill];
        heap_sink();
      end
    end else if (op == OP_REPLACE) begin
      r.key        = heap_keys[0];
      heap_keys[0] = key;
      heap_sink();
    end else begin
      r.key = heap_keys[0];
    end
    r.count = ENTRY_W'(heap_fill);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      heap_fill = 0;
      heap_cap  = CAP_RESET;
      queued_results.delete();
    end else begin
      if (cfg_we)
        heap_cap = cfg_wdata;

      // responses first: one taken at this edge never belongs to a request
      // taken at the same edge
      if (rsp.valid && rsp.ready) begin
        if (queued_results.size() == 0) begin
          $error("response with no request waiting: key_out %0d status %0d count %0d",
                 rsp.key_out, rsp.status, rsp.entry_count);
          errs++;
        end else begin
          oldest = queued_results.pop_front();
          n_checked++;
          if (rsp.key_out !== oldest.key) begin
            $error("key_out mismatch: expected %0d, actual %0d", oldest.key, rsp.key_out);
            errs++;
          end
          if (rsp.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, rsp.status);
            errs++;
          end
          if (rsp.entry_count !== oldest.count) begin
            $error("entry_count mismatch: expected %0d, actual %0d",
                   oldest.count, rsp.entry_count);
            errs++;
          end
          if (oldest.status == ST_FULL)
            n_full++;
          if (oldest.status == ST_EMPTY)
            n_empty++;
        end
      end

      if (req.valid && req.ready) begin
        predicted = heap_predict(req.opcode, req.key_in);
        queued_results.push_back(predicted);
      end
    end

    outstanding   <= queued_results.size();
    fail_count    <= errs;
    checked_count <= n_checked;
    full_count    <= n_full;
    empty_count   <= n_empty;
  end

endmodule

// File: test/min_heap_priority_queue_tb.sv
// Top of the min-heap priority queue testbench: clock, reset, request stimulus,
// response stalls, capacity writes, watchdog and verdict.
// Depends on mhpq_pkg, mhpq_if, the block itself and min_heap_priority_queue_checker.
`timescale 1ns / 1ps

module min_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 6;
  localparam int SETTLE       = 32;    // quiet cycles before a capacity write and at the end
  localparam int STALL_LIMIT  = 4000;  // cycles with no request or response taken
  localparam int HOLD_AFTER   = 250;   // responses taken before the long hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;
  int checked_count;
  int full_count;
  int empty_count;
  int sent_count;
  int cap_writes;
  int burst_left;
  int quiet_cycles;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  min_heap_priority_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  min_heap_priority_queue_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .full_count    (full_count),
    .empty_count   (empty_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // opcode mix leaning toward growth or toward draining
  function automatic opcode_t pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 70) return OP_INSERT;
      if (r < 85) return OP_REMOVE;
      if (r < 95) return OP_REPLACE;
      return OP_PEEK;
    end
    if (r < 25) return OP_INSERT;
    if (r < 75) return OP_REMOVE;
    if (r < 90) return OP_REPLACE;
    return OP_PEEK;
  endfunction

  // full-range keys, a narrow band for ties, the extremes, and a mid window
  function automatic logic signed [KEY_W-1:0] random_key();
    int sel;
    int v;
    sel = $urandom_range(0, 99);
    if (sel < 40)
      return $urandom;
    if (sel < 70) begin
      v = $urandom_range(0, 8);
      return v - 4;
    end
    if (sel < 85) begin
      case ($urandom_range(0, 5))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return KEY_MIN + 1;
        3:       return KEY_MAX - 1;
        4:       return -1;
        default: return 0;
      endcase
    end
    v = $urandom_range(0, 255);
    return 1000 + v;
  endfunction

  // offer one request in bursts with random gaps, return once it is taken
  task automatic send_request(input opcode_t op, input logic signed [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.key_in <= key;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  // stop offering and wait until every response is back and the block is quiet
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CAP_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_writes++;
  endtask

  // request stimulus and verdict
  initial begin
    int phase_caps [PHASES];
    int i;
    int run_left;
    bit filling;

    phase_caps = '{64, 127, 1, 12, 60, 5, 0, 127};
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_PEEK;
    req_ch.key_in <= '0;
    sent_count = 0;
    cap_writes = 0;
    burst_left = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // small heap: empty-heap errors, key extremes, full drop, replace, ties
    write_capacity(3);
    send_request(OP_PEEK, 0);
    send_request(OP_REMOVE, 0);
    send_request(OP_REPLACE, KEY_MAX);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, 0);
    send_request(OP_INSERT, -1);
    send_request(OP_PEEK, 0);
    send_request(OP_REPLACE, KEY_MAX);
    send_request(OP_REMOVE, 0);
    send_request(OP_REMOVE, 0);
    send_request(OP_REMOVE, 0);
    send_request(OP_REMOVE, 0);
    send_request(OP_INSERT, 7);
    send_request(OP_INSERT, 7);
    send_request(OP_INSERT, 7);
    send_request(OP_REPLACE, 7);
    send_request(OP_REMOVE, 0);
    send_request(OP_INSERT, -7);
    wait_idle();

    // capacity zero while keys are still held
    write_capacity(0);
    send_request(OP_INSERT, 5);
    send_request(OP_PEEK, 0);
    send_request(OP_REMOVE, 0);
    wait_idle();

    // random phases, each under its own capacity
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      filling  = 1'b1;
      run_left = $urandom_range(20, 90);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(20, 90);
        end
        run_left--;
        send_request(pick_op(filling), random_key());
      end
      // leave many keys behind so the next, smaller capacity sits below the fill
      if (phase_caps[p] == 60)
        for (i = 0; i < 30; i++)
          send_request(OP_INSERT, random_key());
      wait_idle();
    end

    $display("run covered %0d requests under %0d capacity writes, including a long response hold",
             sent_count, cap_writes);
    $display("%0d responses compared: %0d full drops, %0d empty-heap reports",
             checked_count, full_count, empty_count);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // response side: changing stall patterns, and one long hold-off
  initial begin
    int mode;
    int mode_left;
    int taken;
    bit held;

    mode      = 0;
    mode_left = 0;
    taken     = 0;
    held      = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready)
        taken++;
      if (!held && taken >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= $urandom_range(0, 1);
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles where neither channel moves
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: files.f
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_if.sv
hw/rtl/mhpq_ram.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/min_heap_priority_queue.sv
hw/rtl/mhpq_checker.sv
test/min_heap_priority_queue_checker.sv
test/min_heap_priority_queue_tb.sv
